// ===== design/depth_image_collision_check_unit_macros.svh =====
// Assertion macros used by the depth image collision check sequencer.
`ifndef DEPTH_IMAGE_COLLISION_CHECK_UNIT_MACROS_SVH
`define DEPTH_IMAGE_COLLISION_CHECK_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DICC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DICC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dicc_pkg.sv =====
// Types, constants and helpers of the depth image collision check unit.
package dicc_pkg;

  localparam int IMG_WIDTH  = 640;
  localparam int IMG_HEIGHT = 480;
  localparam int NPIX       = IMG_WIDTH * IMG_HEIGHT;
  localparam int COL_W      = $clog2(IMG_WIDTH);
  localparam int ROW_W      = $clog2(IMG_HEIGHT);
  localparam int ADDR_W     = $clog2(NPIX);
  localparam int MARGIN_MM  = 100;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_NUM_W  = 32;
  localparam int DIV_DEN_W  = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 3'd0,
    CFG_CENTER_Y   = 3'd1,
    CFG_FOCAL_X    = 3'd2,
    CFG_FOCAL_Y    = 3'd3,
    CFG_NEAR_LIMIT = 3'd4,
    CFG_FAR_LIMIT  = 3'd5,
    CFG_INFL_SIDE  = 3'd6,
    CFG_INFL_UP    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FN_WRITE   = 2'd0,
    FN_REBUILD = 2'd1,
    FN_FREE    = 2'd2,
    FN_VFREE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    DS_RAD_H = 3'd0,
    DS_RAD_V = 3'd1,
    DS_COL   = 3'd2,
    DS_ROW   = 3'd3,
    DS_RX    = 3'd4,
    DS_RY    = 3'd5
  } div_sel_t;

  typedef enum logic [2:0] {
    RA_SCAN = 3'd0,
    RA_HWIN = 3'd1,
    RA_VWIN = 3'd2,
    RA_QRY  = 3'd3,
    RA_WIN  = 3'd4
  } rd_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     clr_rst;
    logic     clr_rb;
    logic     a_inc;
    logic     pix_wr;
    logic     scan_rst;
    logic     scan_next_h;
    logic     scan_next_v;
    logic     seed_h;
    logic     seed_v;
    logic     div_start;
    div_sel_t div_sel;
    logic     win_h_init;
    logic     win_v_init;
    logic     k_inc_h;
    logic     k_inc_v;
    rd_sel_t  rd_sel;
    logic     fill_h;
    logic     fill_v;
    logic     q_mul;
    logic     q_sum;
    logic     col_set;
    logic     row_set;
    logic     rx_set;
    logic     ry_set;
    logic     w_next;
    logic     res_set;
    logic     res_free;
    logic     res_oov;
    logic     res_load;
  } cmd_t;

  typedef struct packed {
    logic  in_valid;
    func_t in_func;
    func_t q_func;
    logic  a_last;
    logic  scan_last;
    logic  seed_ok_h;
    logic  seed_ok_v;
    logic  div_busy;
    logic  k_last_h;
    logic  k_last_v;
    logic  z_oov;
    logic  pos_oov;
    logic  occ;
    logic  w_last;
    logic  out_free;
  } sts_t;

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    pix_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(IMG_WIDTH) + ADDR_W'(c));
  endfunction

endpackage

// ===== design/dicc_if.sv =====
// Valid/ready channel interfaces for query words and result words.
interface dicc_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  func;
  logic        [9:0]  pix_col;
  logic        [8:0]  pix_row;
  logic        [15:0] pix_depth_mm;
  logic signed [16:0] point_x_mm;
  logic signed [16:0] point_y_mm;
  logic signed [16:0] point_z_mm;

  modport source (output valid, func, pix_col, pix_row, pix_depth_mm,
                  point_x_mm, point_y_mm, point_z_mm, input ready);
  modport sink (input valid, func, pix_col, pix_row, pix_depth_mm,
                point_x_mm, point_y_mm, point_z_mm, output ready);
endinterface

interface dicc_out_if;
  logic valid;
  logic ready;
  logic is_free;
  logic out_of_view;

  modport source (output valid, is_free, out_of_view, input ready);
  modport sink (input valid, is_free, out_of_view, output ready);
endinterface

// ===== design/dicc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module dicc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [dicc_pkg::DIV_NUM_W-1:0] num,
  input  logic [dicc_pkg::DIV_DEN_W-1:0] den,
  output logic                           busy,
  output logic [dicc_pkg::DIV_NUM_W-1:0] quo
);
  import dicc_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;
  logic [DIV_DEN_W:0]   rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
      rem_r <= rem_nxt[DIV_DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// ===== design/dicc_ctrl.sv =====
// Sequencer for pixel writes, inflation rebuild and point queries.
`include "depth_image_collision_check_unit_macros.svh"

module dicc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  dicc_pkg::sts_t sts,
  output dicc_pkg::cmd_t cmd
);
  import dicc_pkg::*;

  typedef enum logic [30:0] {
    S_CLR    = 31'd1 << 0,
    S_IDLE   = 31'd1 << 1,
    S_WR     = 31'd1 << 2,
    S_RB_CLR = 31'd1 << 3,
    S_H_RD   = 31'd1 << 4,
    S_H_CHK  = 31'd1 << 5,
    S_H_DIV  = 31'd1 << 6,
    S_H_FRD  = 31'd1 << 7,
    S_H_FWR  = 31'd1 << 8,
    S_V_RD   = 31'd1 << 9,
    S_V_CHK  = 31'd1 << 10,
    S_V_DIV  = 31'd1 << 11,
    S_V_FRD  = 31'd1 << 12,
    S_V_FWR  = 31'd1 << 13,
    S_Q_CHK  = 31'd1 << 14,
    S_Q_MUL  = 31'd1 << 15,
    S_Q_SUM  = 31'd1 << 16,
    S_Q_DC   = 31'd1 << 17,
    S_Q_WC   = 31'd1 << 18,
    S_Q_DR   = 31'd1 << 19,
    S_Q_WR   = 31'd1 << 20,
    S_Q_POS  = 31'd1 << 21,
    S_Q_DX   = 31'd1 << 22,
    S_Q_WX   = 31'd1 << 23,
    S_Q_DY   = 31'd1 << 24,
    S_Q_WY   = 31'd1 << 25,
    S_Q_RD   = 31'd1 << 26,
    S_Q_EV   = 31'd1 << 27,
    S_W_RD   = 31'd1 << 28,
    S_W_EV   = 31'd1 << 29,
    S_RESP   = 31'd1 << 30
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_rst = 1'b1;
        cmd.a_inc   = 1'b1;
        if (sts.a_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          unique case (sts.in_func)
            FN_WRITE:   state_nxt = S_WR;
            FN_REBUILD: state_nxt = S_RB_CLR;
            default:    state_nxt = S_Q_CHK;
          endcase
        end
      end
      S_WR: begin
        cmd.pix_wr = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RB_CLR: begin
        cmd.clr_rb = 1'b1;
        cmd.a_inc  = 1'b1;
        if (sts.a_last) begin
          cmd.scan_rst = 1'b1;
          state_nxt    = S_H_RD;
        end
      end
      S_H_RD: begin
        cmd.rd_sel = RA_SCAN;
        state_nxt  = S_H_CHK;
      end
      S_H_CHK: begin
        cmd.seed_h = 1'b1;
        if (sts.seed_ok_h) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_RAD_H;
          state_nxt     = S_H_DIV;
        end else if (sts.scan_last) begin
          cmd.scan_rst = 1'b1;
          state_nxt    = S_V_RD;
        end else begin
          cmd.scan_next_h = 1'b1;
          state_nxt       = S_H_RD;
        end
      end
      S_H_DIV: begin
        cmd.div_sel = DS_RAD_H;
        if (!sts.div_busy) begin
          cmd.win_h_init = 1'b1;
          state_nxt      = S_H_FRD;
        end
      end
      S_H_FRD: begin
        cmd.rd_sel = RA_HWIN;
        state_nxt  = S_H_FWR;
      end
      S_H_FWR: begin
        cmd.fill_h = 1'b1;
        if (!sts.k_last_h) begin
          cmd.k_inc_h = 1'b1;
          state_nxt   = S_H_FRD;
        end else if (sts.scan_last) begin
          cmd.scan_rst = 1'b1;
          state_nxt    = S_V_RD;
        end else begin
          cmd.scan_next_h = 1'b1;
          state_nxt       = S_H_RD;
        end
      end
      S_V_RD: begin
        cmd.rd_sel = RA_SCAN;
        state_nxt  = S_V_CHK;
      end
      S_V_CHK: begin
        cmd.seed_v = 1'b1;
        if (sts.seed_ok_v) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_RAD_V;
          state_nxt     = S_V_DIV;
        end else if (sts.scan_last) begin
          state_nxt = S_RESP;
        end else begin
          cmd.scan_next_v = 1'b1;
          state_nxt       = S_V_RD;
        end
      end
      S_V_DIV: begin
        cmd.div_sel = DS_RAD_V;
        if (!sts.div_busy) begin
          cmd.win_v_init = 1'b1;
          state_nxt      = S_V_FRD;
        end
      end
      S_V_FRD: begin
        cmd.rd_sel = RA_VWIN;
        state_nxt  = S_V_FWR;
      end
      S_V_FWR: begin
        cmd.fill_v = 1'b1;
        if (!sts.k_last_v) begin
          cmd.k_inc_v = 1'b1;
          state_nxt   = S_V_FRD;
        end else if (sts.scan_last) begin
          state_nxt = S_RESP;
        end else begin
          cmd.scan_next_v = 1'b1;
          state_nxt       = S_V_RD;
        end
      end
      S_Q_CHK: begin
        if (sts.z_oov) begin
          cmd.res_set = 1'b1;
          cmd.res_oov = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          state_nxt = S_Q_MUL;
        end
      end
      S_Q_MUL: begin
        cmd.q_mul = 1'b1;
        state_nxt = S_Q_SUM;
      end
      S_Q_SUM: begin
        cmd.q_sum = 1'b1;
        state_nxt = S_Q_DC;
      end
      S_Q_DC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_COL;
        state_nxt     = S_Q_WC;
      end
      S_Q_WC: begin
        if (!sts.div_busy) begin
          cmd.col_set = 1'b1;
          state_nxt   = S_Q_DR;
        end
      end
      S_Q_DR: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_ROW;
        state_nxt     = S_Q_WR;
      end
      S_Q_WR: begin
        if (!sts.div_busy) begin
          cmd.row_set = 1'b1;
          state_nxt   = S_Q_POS;
        end
      end
      S_Q_POS: begin
        if (sts.pos_oov) begin
          cmd.res_set = 1'b1;
          cmd.res_oov = 1'b1;
          state_nxt   = S_RESP;
        end else if (sts.q_func == FN_FREE) begin
          state_nxt = S_Q_RD;
        end else begin
          state_nxt = S_Q_DX;
        end
      end
      S_Q_DX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_RX;
        state_nxt     = S_Q_WX;
      end
      S_Q_WX: begin
        cmd.div_sel = DS_RX;
        if (!sts.div_busy) begin
          cmd.rx_set = 1'b1;
          state_nxt  = S_Q_DY;
        end
      end
      S_Q_DY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_RY;
        state_nxt     = S_Q_WY;
      end
      S_Q_WY: begin
        cmd.div_sel = DS_RY;
        if (!sts.div_busy) begin
          cmd.ry_set = 1'b1;
          state_nxt  = S_W_RD;
        end
      end
      S_Q_RD: begin
        cmd.rd_sel = RA_QRY;
        state_nxt  = S_Q_EV;
      end
      S_Q_EV: begin
        cmd.res_set  = 1'b1;
        cmd.res_free = !sts.occ;
        state_nxt    = S_RESP;
      end
      S_W_RD: begin
        cmd.rd_sel = RA_WIN;
        state_nxt  = S_W_EV;
      end
      S_W_EV: begin
        if (sts.occ) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_RESP;
        end else if (sts.w_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_free = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          cmd.w_next = 1'b1;
          state_nxt  = S_W_RD;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  `DICC_ASSERT_IMP(a_div_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")
  `DICC_ASSERT_NXT(a_acc_once, cmd.in_ready && sts.in_valid, !cmd.in_ready, "second word taken")
  `DICC_ASSERT_IMP(a_res_slot, cmd.res_load, sts.out_free, "pending result overwritten")

endmodule

// ===== design/dicc_dp.sv =====
// Datapath: config registers, image stores, counters, projection and compare.
module dicc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  dicc_in_if.sink                         in_ch,
  dicc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [dicc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dicc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  dicc_pkg::cmd_t                  cmd,
  output dicc_pkg::sts_t                  sts
);
  import dicc_pkg::*;

  function automatic logic [31:0] win_lo(input logic [31:0] c, input logic [31:0] q);
    win_lo = (q > c) ? 32'd0 : c - q;
  endfunction

  function automatic logic [31:0] win_hi(input logic [31:0] c, input logic [31:0] q,
                                         input logic [31:0] mx);
    win_hi = (q > mx - c) ? mx : c + q;
  endfunction

  // configuration
  logic [10:0] cx_r, cy_r;
  logic [11:0] fx_r, fy_r;
  logic [15:0] near_r, far_r, side_r, up_r;
  logic [27:0] prodh_r, prodv_r;
  logic [18:0] c100x_r, c100y_r;

  // latched word
  func_t              func_r;
  logic        [9:0]  pcol_r;
  logic        [8:0]  prow_r;
  logic        [15:0] pdep_r;
  logic signed [16:0] x_r, y_r, z_r;

  // sequencing registers
  logic [ADDR_W-1:0] a_r;
  logic [COL_W-1:0]  u_r, kc_r, khi_r, col_r, c0_r, c1_r, wa_r;
  logic [ROW_W-1:0]  v_r, kr_r, krhi_r, row_r, r0_r, r1_r, wb_r;
  logic [15:0]       d_r;
  logic signed [29:0] mxc_r, myr_r;
  logic [26:0]        mzc_r, mzr_r;
  logic signed [30:0] numc_r, numr_r;
  logic               col_oov_r, row_oov_r;

  // stores
  logic [15:0]       dep_mem  [NPIX];
  logic [15:0]       infl_mem [NPIX];
  logic [15:0]       rp_mem   [NPIX];
  logic [15:0]       dep_rd_r, infl_rd_r, rp_rd_r;
  logic [ADDR_W-1:0] raddr, raddr_q_r;

  logic res_free_r, res_oov_r;
  logic out_valid_r, out_free_r, out_oov_r;

  logic                 in_acc;
  logic                 div_busy;
  logic [DIV_NUM_W-1:0] div_q, div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [31:0]          magc, magr;
  logic                 pix_in_range;
  logic                 fill_h_ok, fill_v_ok;
  logic                 dep_we, infl_we, rp_we;
  logic [ADDR_W-1:0]    dep_waddr, fill_waddr;
  logic [16:0]          occ_d;
  logic signed [17:0]   occ_diff;
  logic [17:0]          occ_abs;
  logic [31:0]          wlo, whi;

  assign in_acc = in_ch.valid && cmd.in_ready;
  assign in_ch.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= 11'd320;
      cy_r   <= 11'd240;
      fx_r   <= 12'd525;
      fy_r   <= 12'd525;
      near_r <= 16'd100;
      far_r  <= 16'd10000;
      side_r <= 16'd100;
      up_r   <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_CENTER_X:   cx_r   <= cfg_data[10:0];
        CFG_CENTER_Y:   cy_r   <= cfg_data[10:0];
        CFG_FOCAL_X:    fx_r   <= cfg_data[11:0];
        CFG_FOCAL_Y:    fy_r   <= cfg_data[11:0];
        CFG_NEAR_LIMIT: near_r <= cfg_data;
        CFG_FAR_LIMIT:  far_r  <= cfg_data;
        CFG_INFL_SIDE:  side_r <= cfg_data;
        CFG_INFL_UP:    up_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // radius numerators follow the registers
  always_ff @(posedge clk) begin
    prodh_r <= 28'(side_r) * 28'(fx_r);
    prodv_r <= 28'(up_r) * 28'(fy_r);
    c100x_r <= 19'(MARGIN_MM) * 19'(fx_r);
    c100y_r <= 19'(MARGIN_MM) * 19'(fy_r);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= func_t'(in_ch.func);
      pcol_r <= in_ch.pix_col;
      prow_r <= in_ch.pix_row;
      pdep_r <= in_ch.pix_depth_mm;
      x_r    <= in_ch.point_x_mm;
      y_r    <= in_ch.point_y_mm;
      z_r    <= in_ch.point_z_mm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         a_r <= '0;
    else if (cmd.a_inc) a_r <= (a_r == ADDR_W'(NPIX - 1)) ? '0 : a_r + 1'b1;
  end

  always_comb begin
    unique case (cmd.div_sel)
      DS_RAD_H: wlo = 32'(u_r);
      DS_RAD_V: wlo = 32'(v_r);
      DS_RX:    wlo = 32'(col_r);
      default:  wlo = 32'(row_r);
    endcase
    whi = win_hi(wlo, div_q, (cmd.div_sel == DS_RAD_H || cmd.div_sel == DS_RX) ?
                 32'(IMG_WIDTH - 1) : 32'(IMG_HEIGHT - 1));
    wlo = win_lo(wlo, div_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r <= '0;
      v_r <= '0;
    end else if (cmd.scan_rst) begin
      u_r <= '0;
      v_r <= '0;
    end else if (cmd.scan_next_h) begin
      if (u_r == COL_W'(IMG_WIDTH - 1)) begin
        u_r <= '0;
        v_r <= v_r + 1'b1;
      end else begin
        u_r <= u_r + 1'b1;
      end
    end else if (cmd.scan_next_v) begin
      if (v_r == ROW_W'(IMG_HEIGHT - 1)) begin
        v_r <= '0;
        u_r <= u_r + 1'b1;
      end else begin
        v_r <= v_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_h) d_r <= dep_rd_r;
    if (cmd.seed_v) d_r <= rp_rd_r;
    if (cmd.win_h_init) begin
      kc_r  <= COL_W'(wlo);
      khi_r <= COL_W'(whi);
    end else if (cmd.k_inc_h) begin
      kc_r <= kc_r + 1'b1;
    end
    if (cmd.win_v_init) begin
      kr_r   <= ROW_W'(wlo);
      krhi_r <= ROW_W'(whi);
    end else if (cmd.k_inc_v) begin
      kr_r <= kr_r + 1'b1;
    end
  end

  // projection
  always_comb begin
    magc = numc_r[30] ? 32'(-numc_r) : 32'(numc_r);
    magr = numr_r[30] ? 32'(-numr_r) : 32'(numr_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.q_mul) begin
      mxc_r <= x_r * $signed({1'b0, fx_r});
      myr_r <= y_r * $signed({1'b0, fy_r});
      mzc_r <= 27'(cx_r) * 27'(z_r[15:0]);
      mzr_r <= 27'(cy_r) * 27'(z_r[15:0]);
    end
    if (cmd.q_sum) begin
      numc_r <= $signed({mxc_r[29], mxc_r}) + $signed({4'b0000, mzc_r});
      numr_r <= $signed({myr_r[29], myr_r}) + $signed({4'b0000, mzr_r});
    end
    if (cmd.col_set) begin
      col_r     <= div_q[COL_W-1:0];
      col_oov_r <= (numc_r[30] && div_q != '0) || div_q >= 32'(IMG_WIDTH);
    end
    if (cmd.row_set) begin
      row_r     <= div_q[ROW_W-1:0];
      row_oov_r <= (numr_r[30] && div_q != '0) || div_q >= 32'(IMG_HEIGHT);
    end
    if (cmd.rx_set) begin
      c0_r <= COL_W'(wlo);
      c1_r <= COL_W'(whi);
    end
    if (cmd.ry_set) begin
      r0_r <= ROW_W'(wlo);
      r1_r <= ROW_W'(whi);
      wa_r <= c0_r;
      wb_r <= ROW_W'(wlo);
    end else if (cmd.w_next) begin
      if (wb_r == r1_r) begin
        wb_r <= r0_r;
        wa_r <= wa_r + 1'b1;
      end else begin
        wb_r <= wb_r + 1'b1;
      end
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DS_RAD_H: begin div_num = 32'(prodh_r); div_den = dep_rd_r;    end
      DS_RAD_V: begin div_num = 32'(prodv_r); div_den = rp_rd_r;     end
      DS_COL:   begin div_num = magc;         div_den = z_r[15:0];   end
      DS_ROW:   begin div_num = magr;         div_den = z_r[15:0];   end
      DS_RX:    begin div_num = 32'(c100x_r); div_den = z_r[15:0];   end
      default:  begin div_num = 32'(c100y_r); div_den = z_r[15:0];   end
    endcase
  end

  dicc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_q)
  );

  // store access
  always_comb begin
    unique case (cmd.rd_sel)
      RA_SCAN: raddr = pix_addr(v_r, u_r);
      RA_HWIN: raddr = pix_addr(v_r, kc_r);
      RA_VWIN: raddr = pix_addr(kr_r, u_r);
      RA_QRY:  raddr = pix_addr(row_r, col_r);
      default: raddr = pix_addr(wb_r, wa_r);
    endcase
    pix_in_range = 32'(pcol_r) < 32'(IMG_WIDTH) && 32'(prow_r) < 32'(IMG_HEIGHT);
    fill_h_ok    = rp_rd_r == '0 || rp_rd_r > d_r;
    fill_v_ok    = infl_rd_r == '0 || infl_rd_r > d_r;
    dep_we       = cmd.clr_rst || (cmd.pix_wr && pix_in_range);
    dep_waddr    = cmd.clr_rst ? a_r : pix_addr(ROW_W'(prow_r), COL_W'(pcol_r));
    infl_we      = cmd.clr_rst || cmd.clr_rb || (cmd.fill_v && fill_v_ok);
    rp_we        = cmd.clr_rb || (cmd.fill_h && fill_h_ok);
    fill_waddr   = (cmd.fill_h || cmd.fill_v) ? raddr_q_r : a_r;
  end

  always_ff @(posedge clk) begin
    if (dep_we) dep_mem[dep_waddr] <= cmd.clr_rst ? 16'd0 : pdep_r;
    dep_rd_r <= dep_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (infl_we) infl_mem[fill_waddr] <= cmd.fill_v ? d_r : 16'd0;
    infl_rd_r <= infl_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rp_we) rp_mem[fill_waddr] <= cmd.fill_h ? d_r : 16'd0;
    rp_rd_r <= rp_mem[raddr];
  end

  always_ff @(posedge clk) begin
    raddr_q_r <= raddr;
  end

  // occupancy at the pixel just read
  always_comb begin
    occ_d    = (func_r == FN_VFREE) ? 17'(z_r[15:0]) + 17'(MARGIN_MM) : 17'(z_r[15:0]);
    occ_diff = $signed({1'b0, occ_d}) - $signed({2'b00, infl_rd_r});
    occ_abs  = occ_diff[17] ? 18'(-occ_diff) : 18'(occ_diff);
  end

  // result slot
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_free_r <= 1'b0;
      res_oov_r  <= 1'b0;
    end else if (cmd.res_set) begin
      res_free_r <= cmd.res_free;
      res_oov_r  <= cmd.res_oov;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (cmd.res_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_free_r <= res_free_r;
      out_oov_r  <= res_oov_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_free     = out_free_r;
  assign out_ch.out_of_view = out_oov_r;

  always_comb begin
    sts           = '0;
    sts.in_valid  = in_ch.valid;
    sts.in_func   = func_t'(in_ch.func);
    sts.q_func    = func_r;
    sts.a_last    = a_r == ADDR_W'(NPIX - 1);
    sts.scan_last = u_r == COL_W'(IMG_WIDTH - 1) && v_r == ROW_W'(IMG_HEIGHT - 1);
    sts.seed_ok_h = dep_rd_r != '0 && dep_rd_r >= near_r && dep_rd_r <= far_r;
    sts.seed_ok_v = rp_rd_r != '0;
    sts.div_busy  = div_busy;
    sts.k_last_h  = kc_r == khi_r;
    sts.k_last_v  = kr_r == krhi_r;
    sts.z_oov     = z_r[16] || z_r == '0 || z_r[15:0] > far_r || z_r[15:0] < near_r;
    sts.pos_oov   = col_oov_r || row_oov_r;
    sts.occ       = (dep_rd_r != '0 && occ_d > 17'(dep_rd_r)) ||
                    (infl_rd_r != '0 && occ_abs < 18'(MARGIN_MM));
    sts.w_last    = wa_r == c1_r && wb_r == r1_r;
    sts.out_free  = !out_valid_r || out_ch.ready;
  end

endmodule

// ===== design/depth_image_collision_check_unit.sv =====
// Depth image collision check: top level joining sequencer and datapath.
// After reset the unit sweeps the depth and inflated stores to zero, one pixel
// a cycle, and takes no word until that sweep is done; configuration writes
// are taken throughout. Items run one at a time. A pixel write passes through
// a write state and the response state. A free query makes two passes through
// the radix-2 divider, for column and row. A very-free query adds two more
// divisions for the window half-sizes and then reads the window pixel by
// pixel, stopping at the first occupied one. A rebuild clears the inflated and
// row-pass stores, then scans the image twice (rows, then columns), with a
// division and a window fill for every seeding pixel. Results sit in an
// output register, one word deep.
module depth_image_collision_check_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  dicc_in_if.sink                         in_ch,
  dicc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [dicc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dicc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dicc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dicc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  dicc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== tb/depth_image_collision_check_unit_tb.sv =====
// Self-checking testbench for the depth image collision check unit.
`timescale 1ns / 1ps
module depth_image_collision_check_unit_tb;
  import dicc_pkg::*;

  localparam longint CYCLE_LIMIT = 80_000_000;

  typedef struct {
    bit is_free;
    bit oov;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dicc_in_if in_ch ();
  dicc_out_if out_ch ();

  depth_image_collision_check_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // predictor state
  bit [15:0] depth_img [NPIX];
  bit [15:0] infl_img [NPIX];
  bit [15:0] row_min [NPIX];
  longint cx, cy, fx, fy, near_mm, far_mm, infl_side, infl_up;

  verdict_t verdict_q[$];
  int errors = 0;
  bit no_idle = 0;
  int stall_left = 0;
  longint cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FN_WRITE;
    in_ch.pix_col = '0;
    in_ch.pix_row = '0;
    in_ch.pix_depth_mm = '0;
    in_ch.point_x_mm = '0;
    in_ch.point_y_mm = '0;
    in_ch.point_z_mm = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("depth_image_collision_check_unit_tb failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  // result checker and sink stalls
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: free=%0b oov=%0b",
                                   out_ch.is_free, out_ch.out_of_view);
      end else begin
        v = verdict_q.pop_front();
        if (out_ch.is_free !== v.is_free || out_ch.out_of_view !== v.oov) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: free exp %0b got %0b, oov exp %0b got %0b",
                     v.is_free, out_ch.is_free, v.oov, out_ch.out_of_view);
        end
      end
    end
    if (no_idle) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 20) begin
      stall_left = gap_len();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic bit occupied_at(longint c, longint r, longint d);
    longint s, e, diff;
    s = depth_img[r * IMG_WIDTH + c];
    e = infl_img[r * IMG_WIDTH + c];
    diff = d - e;
    if (diff < 0) diff = -diff;
    return (s != 0 && d > s) || (e != 0 && diff < MARGIN_MM);
  endfunction

  function automatic void rebuild_inflation();
    longint rad, lo, hi, d;
    for (int i = 0; i < NPIX; i++) begin
      row_min[i] = 0;
      infl_img[i] = 0;
    end
    for (int v = 0; v < IMG_HEIGHT; v++)
      for (int u = 0; u < IMG_WIDTH; u++) begin
        d = depth_img[v * IMG_WIDTH + u];
        if (d == 0 || d < near_mm || d > far_mm) continue;
        rad = infl_side * fx / d;
        lo = (u - rad < 0) ? 0 : u - rad;
        hi = (u + rad > IMG_WIDTH - 1) ? IMG_WIDTH - 1 : u + rad;
        for (longint k = lo; k <= hi; k++)
          if (row_min[v * IMG_WIDTH + k] == 0 || row_min[v * IMG_WIDTH + k] > d)
            row_min[v * IMG_WIDTH + k] = d[15:0];
      end
    for (int u = 0; u < IMG_WIDTH; u++)
      for (int v = 0; v < IMG_HEIGHT; v++) begin
        d = row_min[v * IMG_WIDTH + u];
        if (d == 0) continue;
        rad = infl_up * fy / d;
        lo = (v - rad < 0) ? 0 : v - rad;
        hi = (v + rad > IMG_HEIGHT - 1) ? IMG_HEIGHT - 1 : v + rad;
        for (longint k = lo; k <= hi; k++)
          if (infl_img[k * IMG_WIDTH + u] == 0 || infl_img[k * IMG_WIDTH + u] > d)
            infl_img[k * IMG_WIDTH + u] = d[15:0];
      end
  endfunction

  function automatic verdict_t predict_word(func_t f, bit [9:0] col, bit [8:0] row,
                                            bit [15:0] dep, logic signed [16:0] xs,
                                            logic signed [16:0] ys,
                                            logic signed [16:0] zs);
    verdict_t v;
    longint x, y, z, pc, pr, rx, ry, c0, c1, r0, r1;
    x = xs;
    y = ys;
    z = zs;
    v.is_free = 0;
    v.oov = 0;
    if (f == FN_WRITE) begin
      if (col < IMG_WIDTH && row < IMG_HEIGHT) depth_img[row * IMG_WIDTH + col] = dep;
      return v;
    end
    if (f == FN_REBUILD) begin
      rebuild_inflation();
      return v;
    end
    if (z <= 0 || z > far_mm || z < near_mm) begin
      v.oov = 1;
      return v;
    end
    pc = (x * fx + cx * z) / z;
    pr = (y * fy + cy * z) / z;
    if (pc < 0 || pc >= IMG_WIDTH || pr < 0 || pr >= IMG_HEIGHT) begin
      v.oov = 1;
      return v;
    end
    if (f == FN_FREE) begin
      v.is_free = !occupied_at(pc, pr, z);
      return v;
    end
    rx = MARGIN_MM * fx / z;
    ry = MARGIN_MM * fy / z;
    c0 = (pc - rx < 0) ? 0 : pc - rx;
    c1 = (pc + rx > IMG_WIDTH - 1) ? IMG_WIDTH - 1 : pc + rx;
    r0 = (pr - ry < 0) ? 0 : pr - ry;
    r1 = (pr + ry > IMG_HEIGHT - 1) ? IMG_HEIGHT - 1 : pr + ry;
    for (longint a = c0; a <= c1; a++)
      for (longint b = r0; b <= r1; b++)
        if (occupied_at(a, b, z + MARGIN_MM)) return v;
    v.is_free = 1;
    return v;
  endfunction

  task automatic send_word(func_t f, int col, int row, int dep, int x, int y, int z);
    int gap;
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.pix_col <= col[9:0];
    in_ch.pix_row <= row[8:0];
    in_ch.pix_depth_mm <= dep[15:0];
    in_ch.point_x_mm <= x[16:0];
    in_ch.point_y_mm <= y[16:0];
    in_ch.point_z_mm <= z[16:0];
    do @(posedge clk); while (!in_ch.ready);
    verdict_q.insert(verdict_q.size(),
                     predict_word(f, col[9:0], row[8:0], dep[15:0],
                                  x[16:0], y[16:0], z[16:0]));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, int val);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_data <= val[15:0];
    case (r)
      CFG_CENTER_X:   cx = val & 16'h7FF;
      CFG_CENTER_Y:   cy = val & 16'h7FF;
      CFG_FOCAL_X:    fx = val & 16'hFFF;
      CFG_FOCAL_Y:    fy = val & 16'hFFF;
      CFG_NEAR_LIMIT: near_mm = val & 16'hFFFF;
      CFG_FAR_LIMIT:  far_mm = val & 16'hFFFF;
      CFG_INFL_SIDE:  infl_side = val & 16'hFFFF;
      default:        infl_up = val & 16'hFFFF;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(int c_x, int c_y, int f_x, int f_y, int nr, int fr,
                            int side, int up);
    wait_drained();
    write_reg(CFG_CENTER_X, c_x);
    write_reg(CFG_CENTER_Y, c_y);
    write_reg(CFG_FOCAL_X, f_x);
    write_reg(CFG_FOCAL_Y, f_y);
    write_reg(CFG_NEAR_LIMIT, nr);
    write_reg(CFG_FAR_LIMIT, fr);
    write_reg(CFG_INFL_SIDE, side);
    write_reg(CFG_INFL_UP, up);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // point at depth z that projects near pixel (tc, tr)
  task automatic query_at(func_t f, int tc, int tr, int z);
    longint x, y;
    x = (longint'(tc) - cx) * z / ((fx == 0) ? 1 : fx) + $urandom_range(0, 2) - 1;
    y = (longint'(tr) - cy) * z / ((fy == 0) ? 1 : fy) + $urandom_range(0, 2) - 1;
    if (x > 65535) x = 65535;
    if (x < -65536) x = -65536;
    if (y > 65535) y = 65535;
    if (y < -65536) y = -65536;
    send_word(f, 0, 0, 0, int'(x), int'(y), z);
  endtask

  task automatic test_defaults();
    no_idle = 1;
    send_word(FN_WRITE, 320, 240, 1000, 0, 0, 0);
    send_word(FN_WRITE, 0, 0, 65535, 0, 0, 0);
    send_word(FN_WRITE, 639, 479, 100, 0, 0, 0);
    send_word(FN_WRITE, 1023, 511, 500, 0, 0, 0);
    send_word(FN_WRITE, 700, 10, 500, 0, 0, 0);
    send_word(FN_WRITE, 10, 480, 500, 0, 0, 0);
    send_word(FN_WRITE, 10, 10, 0, 0, 0, 0);
    no_idle = 0;
    send_word(FN_REBUILD, 0, 0, 0, 0, 0, 0);
    send_word(FN_FREE, 0, 0, 0, 0, 0, 1000);
    send_word(FN_FREE, 0, 0, 0, 0, 0, 1200);
    send_word(FN_FREE, 0, 0, 0, 0, 0, 0);
    send_word(FN_FREE, 0, 0, 0, 0, 0, -5);
    send_word(FN_FREE, 0, 0, 0, 0, 0, -65536);
    send_word(FN_FREE, 0, 0, 0, 0, 0, 99);
    send_word(FN_FREE, 0, 0, 0, 0, 0, 10001);
    // column just left of zero truncates to the first column
    send_word(FN_FREE, 0, 0, 0, -610, 0, 1000);
    send_word(FN_FREE, 0, 0, 0, 65535, 0, 100);
    send_word(FN_FREE, 0, 0, 0, 0, -65536, 100);
    send_word(FN_VFREE, 0, 0, 0, 0, 0, 2000);
    send_word(FN_VFREE, 0, 0, 0, -609, 0, 1000);
    send_word(FN_VFREE, 0, 0, 0, 0, 0, 9000);
    query_at(FN_FREE, 10, 10, 3000);
    query_at(FN_VFREE, 639, 479, 5000);
  endtask

  task automatic test_extreme_config();
    // one seed at near = far, full-size inflation clipped to the image
    set_config(2047, 0, 4095, 4095, 777, 777, 65535, 65535);
    send_word(FN_WRITE, 100, 100, 777, 0, 0, 0);
    send_word(FN_REBUILD, 0, 0, 0, 0, 0, 0);
    set_config(0, 2047, 4095, 1, 0, 65535, 0, 0);
    send_word(FN_FREE, 0, 0, 0, 0, 0, 777);
    send_word(FN_FREE, 0, 0, 0, 0, -2047, 1);
    send_word(FN_FREE, 0, 0, 0, 100, -65536, 65535);
    send_word(FN_VFREE, 0, 0, 0, 1000, -65536, 65535);
    set_config(0, 0, 0, 0, 1, 65535, 0, 0);
    send_word(FN_FREE, 0, 0, 0, 5000, 5000, 700);
    send_word(FN_VFREE, 0, 0, 0, -5000, 77, 800);
    set_config(2047, 2047, 0, 0, 1, 65535, 0, 0);
    send_word(FN_FREE, 0, 0, 0, 5, 5, 700);
  endtask

  task automatic test_random_scene(int n_items);
    int sc, sr, n_seeds, vf_zmin, zlo, r, tc, tr, z;
    set_config($urandom_range(200, 440), $urandom_range(150, 330),
               $urandom_range(200, 600), $urandom_range(200, 600),
               $urandom_range(0, 1400), $urandom_range(3000, 20000),
               $urandom_range(20, 120), $urandom_range(20, 120));
    sc = $urandom_range(40, 599);
    sr = $urandom_range(40, 439);
    n_seeds = $urandom_range(20, 40);
    for (int i = 0; i < n_seeds; i++)
      send_word(FN_WRITE, sc + $urandom_range(0, 80) - 40, sr + $urandom_range(0, 80) - 40,
                $urandom_range(1500, 6000), 0, 0, 0);
    for (int i = 0; i < 6; i++)
      send_word(FN_WRITE, $urandom_range(0, 1023), $urandom_range(0, 511),
                $urandom_range(0, 65535) & 16'h00FF, 0, 0, 0);
    send_word(FN_REBUILD, 0, 0, 0, 0, 0, 0);
    vf_zmin = int'(100 * ((fx > fy) ? fx : fy) / 12) + 1;
    zlo = (near_mm > 1) ? int'(near_mm) : 1;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_drained();
      no_idle = (i % 200) < 30;
      r = $urandom_range(0, 99);
      tc = sc + $urandom_range(0, 120) - 60;
      tr = sr + $urandom_range(0, 120) - 60;
      if (tc < 0) tc = 0;
      if (tc > IMG_WIDTH - 1) tc = IMG_WIDTH - 1;
      if (tr < 0) tr = 0;
      if (tr > IMG_HEIGHT - 1) tr = IMG_HEIGHT - 1;
      z = $urandom_range(1400, 7000);
      if (z < zlo) z = zlo;
      if (r < 55) begin
        query_at(FN_FREE, tc, tr, z);
      end else if (r < 75) begin
        if (z < vf_zmin) z = vf_zmin;
        if (z > 65535) z = 65535;
        query_at(FN_VFREE, tc, tr, z);
      end else if (r < 85) begin
        send_word(FN_WRITE, tc, tr, $urandom_range(0, 65535), 0, 0, 0);
      end else if (r < 92) begin
        send_word(FN_FREE, $urandom_range(0, 1023), $urandom_range(0, 511),
                  $urandom_range(0, 65535), $urandom_range(0, 131071),
                  $urandom_range(0, 131071), $urandom_range(0, 131071));
      end else if (r < 96) begin
        send_word(FN_VFREE, 0, 0, 0, $urandom_range(0, 131071),
                  $urandom_range(0, 131071), $urandom_range(0, 65535) | 17'h10000);
      end else begin
        send_word(FN_WRITE, $urandom_range(640, 1023), $urandom_range(0, 511),
                  $urandom_range(0, 65535), 0, 0, 0);
      end
    end
    no_idle = 0;
  endtask

  initial begin
    cx = 320; cy = 240; fx = 525; fy = 525;
    near_mm = 100; far_mm = 10000; infl_side = 100; infl_up = 100;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_extreme_config();
    for (int s = 0; s < 3; s++) test_random_scene(460);
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("depth_image_collision_check_unit_tb passed");
    end else begin
      $display("depth_image_collision_check_unit_tb failed");
    end
    $finish;
  end

endmodule
